// ----- hdl/windowed_rate_quartile_gate_core_macros.svh -----
// Assertion macros shared by the rate quartile gate modules.
`ifndef WINDOWED_RATE_QUARTILE_GATE_CORE_MACROS_SVH
`define WINDOWED_RATE_QUARTILE_GATE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define WRQG_ASSERT_IMP(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define WRQG_ASSERT_NXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- hdl/wrqg_pkg.sv -----
// Shared constants, types and helpers of the rate quartile gate.
`default_nettype none
package wrqg_pkg;

	localparam int WINDOW_DEPTH = 64;
	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);

	localparam int TS_W = 48;
	localparam int RATE_W = 10;
	localparam int WIN_W = 24;
	localparam int MSC_W = 7;
	localparam int PCT_W = 7;
	localparam int WGT_W = 4;
	localparam int IDX_W = 3;
	localparam int CFG_DW = 24;
	localparam int BIT_W = $clog2(RATE_W);
	localparam int CMP_W = (CW > MSC_W) ? CW : MSC_W;
	localparam int PROD_W = RATE_W + PCT_W + 1;
	localparam int MW_W = WGT_W + RATE_W;
	localparam int SUM_W = MW_W + 1;
	localparam int PCT_BASE = 100;

	localparam int NLANE = 3;
	localparam int LANE_MIN = 0;
	localparam int LANE_Q3 = 1;
	localparam int LANE_MED = 2;

	localparam logic [IDX_W-1:0] CFG_WINDOW_LENGTH = 3'd0;
	localparam logic [IDX_W-1:0] CFG_MIN_COUNT = 3'd1;
	localparam logic [IDX_W-1:0] CFG_MIN_MEDIAN = 3'd2;
	localparam logic [IDX_W-1:0] CFG_VIDEO_RATE = 3'd3;
	localparam logic [IDX_W-1:0] CFG_STABLE_PCT = 3'd4;
	localparam logic [IDX_W-1:0] CFG_MISS_WEIGHT = 3'd5;

	localparam logic [WIN_W-1:0] RST_WINDOW_LENGTH = 24'd500000;
	localparam logic [MSC_W-1:0] RST_MIN_COUNT = 7'd4;
	localparam logic [RATE_W-1:0] RST_MIN_MEDIAN = 10'd5;
	localparam logic [RATE_W-1:0] RST_VIDEO_RATE = 10'd24;
	localparam logic [PCT_W-1:0] RST_STABLE_PCT = 7'd80;
	localparam logic [WGT_W-1:0] RST_MISS_WEIGHT = 4'd3;

	typedef struct packed {
		logic latch;
		logic exp_pop;
		logic append;
		logic sel_init;
		logic sel_issue;
		logic sel_resolve;
		logic [BIT_W-1:0] bit_idx;
		logic dec_load;
		logic res_load;
		logic res_short;
	} wrqg_cmd_t;

	typedef struct packed {
		logic is_query;
		logic cnt_zero;
		logic exp_hit;
		logic query_ok;
		logic issue_done;
		logic rd_vld;
	} wrqg_stat_t;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p,
			input logic [CW-1:0] c);
		logic [AW:0] s;
		s = (AW + 1)'(p) + (AW + 1)'(c);
		if (s >= (AW + 1)'(WINDOW_DEPTH)) begin
			s = s - (AW + 1)'(WINDOW_DEPTH);
		end
		return s[AW-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- hdl/wrqg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wrqg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- hdl/wrqg_ctrl.sv -----
// Sequencer of the rate quartile gate: expiry, append, selection passes, decision.
`default_nettype none
module wrqg_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire wrqg_pkg::wrqg_stat_t stat,
	output wrqg_pkg::wrqg_cmd_t       cmd,
	output logic                      busy,
	output logic                      done
);
	import wrqg_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXP_RD,
		ST_EXP_CHK,
		ST_APPEND,
		ST_QUERY,
		ST_SEL,
		ST_DEC1,
		ST_DEC2
	} state_t;

	state_t state_q, state_d, post_st;
	logic [BIT_W-1:0] bit_q, bit_d;
	logic busy_q, busy_d;
	logic done_q, done_d;

	always_comb begin
		cmd = '0;
		cmd.bit_idx = bit_q;
		state_d = state_q;
		bit_d = bit_q;
		busy_d = busy_q;
		done_d = 1'b0;
		post_st = stat.is_query ? ST_QUERY : ST_APPEND;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					busy_d = 1'b1;
					state_d = ST_EXP_RD;
				end
			end
			ST_EXP_RD: begin
				state_d = stat.cnt_zero ? post_st : ST_EXP_CHK;
			end
			ST_EXP_CHK: begin
				if (stat.exp_hit) begin
					cmd.exp_pop = 1'b1;
					state_d = ST_EXP_RD;
				end else begin
					state_d = post_st;
				end
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				busy_d = 1'b0;
				state_d = ST_IDLE;
			end
			ST_QUERY: begin
				if (stat.query_ok) begin
					cmd.sel_init = 1'b1;
					bit_d = BIT_W'(RATE_W - 1);
					state_d = ST_SEL;
				end else begin
					cmd.res_load = 1'b1;
					cmd.res_short = 1'b1;
					busy_d = 1'b0;
					done_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SEL: begin
				cmd.sel_issue = !stat.issue_done;
				if (stat.issue_done && !stat.rd_vld) begin
					cmd.sel_resolve = 1'b1;
					if (bit_q == '0) begin
						state_d = ST_DEC1;
					end else begin
						bit_d = bit_q - 1'b1;
					end
				end
			end
			ST_DEC1: begin
				cmd.dec_load = 1'b1;
				state_d = ST_DEC2;
			end
			ST_DEC2: begin
				cmd.res_load = 1'b1;
				busy_d = 1'b0;
				done_d = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			bit_q <= bit_d;
			busy_q <= busy_d;
			done_q <= done_d;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

`include "windowed_rate_quartile_gate_core_macros.svh"

	`WRQG_ASSERT_IMP(a_done_not_busy, done_q, !busy_q, "result strobe while busy")
	`WRQG_ASSERT_NXT(a_start_busy, start && !busy_q, busy_q, "item taken but not busy")
	`WRQG_ASSERT_NXT(a_res_done, cmd.res_load, done_q, "result loaded without strobe")

endmodule
`default_nettype wire

// ----- hdl/wrqg_dp.sv -----
// Datapath of the rate quartile gate: sample stores, window pointers, rank lanes, decision.
`default_nettype none
module wrqg_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire wrqg_pkg::wrqg_cmd_t          cmd,
	output wrqg_pkg::wrqg_stat_t              stat,
	input  wire logic                         in_cmd,
	input  wire logic [wrqg_pkg::TS_W-1:0]    in_ts,
	input  wire logic [wrqg_pkg::RATE_W-1:0]  in_enc,
	input  wire logic [wrqg_pkg::RATE_W-1:0]  in_ack,
	input  wire logic [wrqg_pkg::RATE_W-1:0]  in_miss,
	input  wire logic                         cfg_we,
	input  wire logic [wrqg_pkg::IDX_W-1:0]   cfg_idx,
	input  wire logic [wrqg_pkg::CFG_DW-1:0]  cfg_wdata,
	output logic                              res_avoid,
	output logic      [wrqg_pkg::CW-1:0]      res_count
);
	import wrqg_pkg::*;

	logic [WIN_W-1:0] win_q;
	logic [MSC_W-1:0] msc_q;
	logic [RATE_W-1:0] min_med_q;
	logic [RATE_W-1:0] video_q;
	logic [PCT_W-1:0] pct_q;
	logic [WGT_W-1:0] wgt_q;

	logic cmd_q;
	logic [TS_W-1:0] now_q;
	logic [RATE_W-1:0] enc_q, ack_in_q, miss_in_q;
	logic [RATE_W-1:0] ack_lat_q, miss_lat_q;

	logic [AW-1:0] head_q;
	logic [CW-1:0] live_count_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] sel_idx_q;
	logic rd_vld_s1;

	logic [RATE_W-1:0] prefix_q [NLANE];
	logic [AW-1:0] rank_q [NLANE];
	logic [CW-1:0] cnt_q [NLANE];
	logic [NLANE-1:0] match;

	logic full;
	logic [AW-1:0] slot;
	logic [TS_W-1:0] time_rdata;
	logic [RATE_W-1:0] rate_rdata;
	logic [RATE_W-1:0] hi_mask;
	logic [CW-1:0] quarter;
	logic [CW-1:0] rank_q3, rank_med;

	logic med_ok_s1, vid_ok_s1;
	logic [PROD_W-1:0] pp_s1, lim_s1;
	logic [MW_W-1:0] mw_s1;
	logic [SUM_W-1:0] ack_sum;
	logic avoid_d;
	logic avoid_q;
	logic [CW-1:0] count_q;

	assign full = (live_count_q == CW'(WINDOW_DEPTH));
	assign slot = full ? head_q : ptr_add(head_q, live_count_q);

	wrqg_ram #(.WIDTH(TS_W), .DEPTH(WINDOW_DEPTH)) u_time_ram (
		.clk   (clk),
		.we    (cmd.append),
		.waddr (slot),
		.wdata (now_q),
		.raddr (head_q),
		.rdata (time_rdata)
	);

	wrqg_ram #(.WIDTH(RATE_W), .DEPTH(WINDOW_DEPTH)) u_rate_ram (
		.clk   (clk),
		.we    (cmd.append),
		.waddr (slot),
		.wdata (enc_q),
		.raddr (rd_ptr_q),
		.rdata (rate_rdata)
	);

	assign stat.is_query = cmd_q;
	assign stat.cnt_zero = (live_count_q == '0);
	assign stat.exp_hit = (now_q >= time_rdata)
		&& ((now_q - time_rdata) >= TS_W'(win_q));
	assign stat.query_ok = (live_count_q != '0)
		&& (CMP_W'(live_count_q) >= CMP_W'(msc_q));
	assign stat.issue_done = (sel_idx_q == live_count_q);
	assign stat.rd_vld = rd_vld_s1;

	assign quarter = live_count_q >> 2;
	assign rank_q3 = live_count_q - CW'(1) - quarter;
	assign rank_med = live_count_q - CW'(1) - (quarter << 1);

	assign hi_mask = {RATE_W{1'b1}} << ((BIT_W + 1)'(cmd.bit_idx) + (BIT_W + 1)'(1));

	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			match[l] = (((rate_rdata ^ prefix_q[l]) & hi_mask) == '0)
				&& !rate_rdata[cmd.bit_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= RST_WINDOW_LENGTH;
			msc_q <= RST_MIN_COUNT;
			min_med_q <= RST_MIN_MEDIAN;
			video_q <= RST_VIDEO_RATE;
			pct_q <= RST_STABLE_PCT;
			wgt_q <= RST_MISS_WEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_WINDOW_LENGTH: win_q <= cfg_wdata[WIN_W-1:0];
				CFG_MIN_COUNT: msc_q <= cfg_wdata[MSC_W-1:0];
				CFG_MIN_MEDIAN: min_med_q <= cfg_wdata[RATE_W-1:0];
				CFG_VIDEO_RATE: video_q <= cfg_wdata[RATE_W-1:0];
				CFG_STABLE_PCT: pct_q <= cfg_wdata[PCT_W-1:0];
				CFG_MISS_WEIGHT: wgt_q <= cfg_wdata[WGT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			live_count_q <= '0;
			ack_lat_q <= '0;
			miss_lat_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.sel_issue;
			if (cmd.exp_pop) begin
				head_q <= ptr_inc(head_q);
				live_count_q <= live_count_q - 1'b1;
			end else if (cmd.append) begin
				if (full) begin
					head_q <= ptr_inc(head_q);
				end else begin
					live_count_q <= live_count_q + 1'b1;
				end
				ack_lat_q <= ack_in_q;
				miss_lat_q <= miss_in_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q <= in_cmd;
			now_q <= in_ts;
			enc_q <= in_enc;
			ack_in_q <= in_ack;
			miss_in_q <= in_miss;
		end
		if (cmd.sel_init || cmd.sel_resolve) begin
			rd_ptr_q <= head_q;
			sel_idx_q <= '0;
		end else if (cmd.sel_issue) begin
			rd_ptr_q <= ptr_inc(rd_ptr_q);
			sel_idx_q <= sel_idx_q + 1'b1;
		end
		for (int l = 0; l < NLANE; l++) begin
			if (cmd.sel_init || cmd.sel_resolve) begin
				cnt_q[l] <= '0;
			end else if (rd_vld_s1 && match[l]) begin
				cnt_q[l] <= cnt_q[l] + 1'b1;
			end
			if (cmd.sel_init) begin
				prefix_q[l] <= '0;
			end else if (cmd.sel_resolve && (CW'(rank_q[l]) >= cnt_q[l])) begin
				prefix_q[l][cmd.bit_idx] <= 1'b1;
				rank_q[l] <= rank_q[l] - AW'(cnt_q[l]);
			end
		end
		if (cmd.sel_init) begin
			rank_q[LANE_MIN] <= '0;
			rank_q[LANE_Q3] <= AW'(rank_q3);
			rank_q[LANE_MED] <= AW'(rank_med);
		end
		if (cmd.dec_load) begin
			med_ok_s1 <= prefix_q[LANE_MED] >= min_med_q;
			vid_ok_s1 <= prefix_q[LANE_MED] >= video_q;
			pp_s1 <= PROD_W'(prefix_q[LANE_MED]) * PROD_W'(pct_q);
			lim_s1 <= (PROD_W'(prefix_q[LANE_MIN]) + PROD_W'(1)) * PROD_W'(PCT_BASE);
			mw_s1 <= MW_W'(wgt_q) * MW_W'(miss_lat_q);
		end
		if (cmd.res_load) begin
			avoid_q <= avoid_d;
			count_q <= live_count_q;
		end
	end

	assign ack_sum = SUM_W'(prefix_q[LANE_Q3]) + SUM_W'(mw_s1);
	assign avoid_d = !cmd.res_short && med_ok_s1 && (vid_ok_s1 || (pp_s1 < lim_s1))
		&& (ack_sum >= SUM_W'(ack_lat_q));

	assign res_avoid = avoid_q;
	assign res_count = count_q;

`include "windowed_rate_quartile_gate_core_macros.svh"

	`WRQG_ASSERT_IMP(a_count_bound, 1'b1, live_count_q <= CW'(WINDOW_DEPTH), "count past depth")
	`WRQG_ASSERT_IMP(a_pop_nonempty, cmd.exp_pop, live_count_q != '0, "expiry of empty window")
	`WRQG_ASSERT_NXT(a_append_live, cmd.append, live_count_q != '0, "append left window empty")

endmodule
`default_nettype wire

// ----- hdl/windowed_rate_quartile_gate_core.sv -----
// Top level of the windowed rate quartile gate.
//
//  channel   handshake                 payload
//  item in   start & !busy             cmd, timestamp_us, frame_rate, ack_rate, missing_acks
//  result    done (one-cycle strobe)   avoid_stereo, window_count
//  config    cfg_valid & cfg_ready     cfg_index, cfg_data
//
// Record: busy through expiry of old samples, then the append; a record gives no done.
// Query: busy through expiry, then ten bit passes of one read a cycle over the n live
// samples, then the decision; with too few samples just expiry. done rises as busy falls.
// Reset clears the window and loads default registers; no clearing pass is needed.
// The result strobe cannot be stalled; cfg_ready is always high.
`default_nettype none
module windowed_rate_quartile_gate_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         cmd,
	input  wire logic [wrqg_pkg::TS_W-1:0]    timestamp_us,
	input  wire logic [wrqg_pkg::RATE_W-1:0]  frame_rate,
	input  wire logic [wrqg_pkg::RATE_W-1:0]  ack_rate,
	input  wire logic [wrqg_pkg::RATE_W-1:0]  missing_acks,
	output logic                              done,
	output logic                              avoid_stereo,
	output logic      [wrqg_pkg::CW-1:0]      window_count,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [wrqg_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [wrqg_pkg::CFG_DW-1:0]  cfg_data
);
	import wrqg_pkg::*;

	wrqg_cmd_t ctl_cmd;
	wrqg_stat_t dp_stat;

	assign cfg_ready = 1'b1;

	wrqg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (dp_stat),
		.cmd    (ctl_cmd),
		.busy   (busy),
		.done   (done)
	);

	wrqg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ctl_cmd),
		.stat      (dp_stat),
		.in_cmd    (cmd),
		.in_ts     (timestamp_us),
		.in_enc    (frame_rate),
		.in_ack    (ack_rate),
		.in_miss   (missing_acks),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.res_avoid (avoid_stereo),
		.res_count (window_count)
	);

endmodule
`default_nettype wire
